/* sv/arc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pkg: shared types and constants
// Entry states, codes and the compare-unit result type for the neighbor
// cache.
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int OUT_IDX_W     = 4;
    localparam int AGE_W         = 8;
    localparam int MAC_W         = 48;
    localparam int ADDR_W        = 64;

    localparam logic [AGE_W-1:0] STABLE_LIMIT_RST  = 8'd240;
    localparam logic [AGE_W-1:0] PENDING_LIMIT_RST = 8'd2;

    localparam logic [1:0] ACT_QUERY  = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    localparam logic [1:0] RES_OK         = 2'd0;
    localparam logic [1:0] RES_NO_ENTRY   = 2'd1;
    localparam logic [1:0] RES_UNRESOLVED = 2'd2;

    localparam logic CFG_STABLE_LIMIT  = 1'b0;
    localparam logic CFG_PENDING_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        ENT_EMPTY   = 2'd0,
        ENT_PENDING = 2'd1,
        ENT_STABLE  = 2'd2
    } t_ent;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_SWEEP,
        S_PICK,
        S_APPLY,
        S_TICK
    } t_state;

    typedef struct packed {
        logic match;
        logic age_ge;
    } t_cmp;

endpackage

/* sv/arc_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_cmp: shared compare unit
// Compares one table entry against the key address and its age against the
// running oldest age.
// ----------------------------------------------------------------------------
module arc_cmp (
    input  logic [arc_pkg::ADDR_W-1:0] i_ent_hi,
    input  logic [arc_pkg::ADDR_W-1:0] i_ent_lo,
    input  logic                       i_ent_v,
    input  logic [arc_pkg::ADDR_W-1:0] i_key_hi,
    input  logic [arc_pkg::ADDR_W-1:0] i_key_lo,
    input  logic                       i_key_v,
    input  logic [arc_pkg::AGE_W-1:0]  i_ent_age,
    input  logic [arc_pkg::AGE_W-1:0]  i_ref_age,
    output arc_pkg::t_cmp              o_res
);
    import arc_pkg::*;

    always_comb begin
        o_res.match  = (i_ent_hi == i_key_hi) && (i_ent_lo == i_key_lo) && (i_ent_v == i_key_v);
        o_res.age_ge = (i_ent_age >= i_ref_age);
    end

endmodule

/* sv/address_resolution_cache_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_resolution_cache_core: IPv4/IPv6 neighbor cache with aging
// Query, update and tick items run under a small sequencer that walks the
// table one entry per cycle through a single shared compare unit.
// ----------------------------------------------------------------------------
// Order: query/update goes straight from the last-hit check to apply on a match;
//   else sweep, pick, apply (a sweep match skips pick; no entry ends at pick);
//   tick walks the table; an unused action code returns its result from idle.
// Throughput: one item in flight; the next item is taken once the result is taken.
// Reset: synchronous, active low; all entries empty with age 0, last hit 0,
//   limits 240 / 2. No clearing pass is needed.
module address_resolution_cache_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input item channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_action,
    input  logic [arc_pkg::ADDR_W-1:0] i_addr_high,
    input  logic [arc_pkg::ADDR_W-1:0] i_addr_low,
    input  logic                       i_is_ipv6,
    input  logic [arc_pkg::MAC_W-1:0]  i_mac_in,
    input  logic                       i_has_packet,
    input  logic                       i_allow_recycle,
    // result item channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic [arc_pkg::OUT_IDX_W-1:0] o_entry_index,
    output logic [arc_pkg::MAC_W-1:0]  o_mac_out,
    output logic                       o_send_request,
    output logic                       o_send_packet,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [arc_pkg::AGE_W-1:0]  i_cfg_data
);
    import arc_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Table: status and age reset, address and MAC written before first read
    t_ent               r_status [TABLE_ENTRIES];
    logic [AGE_W-1:0]   r_age    [TABLE_ENTRIES];
    logic [ADDR_W-1:0]  r_ent_hi [TABLE_ENTRIES];
    logic [ADDR_W-1:0]  r_ent_lo [TABLE_ENTRIES];
    logic               r_ent_v  [TABLE_ENTRIES];
    logic [MAC_W-1:0]   r_ent_mac[TABLE_ENTRIES];
    logic [IDX_W-1:0]   r_last;

    logic [AGE_W-1:0]   r_stable_lim;
    logic [AGE_W-1:0]   r_pending_lim;

    // Captured item
    logic [1:0]         r_act;
    logic [ADDR_W-1:0]  r_hi;
    logic [ADDR_W-1:0]  r_lo;
    logic               r_v;
    logic [MAC_W-1:0]   r_mac;
    logic               r_pkt;
    logic               r_rcy;

    // Sweep trackers
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_idx;
    logic               r_fe_vld, r_os_vld, r_op_vld;
    logic [IDX_W-1:0]   r_fe, r_os, r_op;
    logic [AGE_W-1:0]   r_os_age, r_op_age;

    // Result register
    logic               r_ov;
    logic [1:0]         r_res_st;
    logic [IDX_W-1:0]   r_res_idx;
    logic [MAC_W-1:0]   r_res_mac;
    logic               r_res_req;
    logic               r_res_snd;

    logic               in_acc;
    logic [IDX_W-1:0]   rd_idx;
    t_ent               rd_st;
    t_cmp               cmp;
    logic [AGE_W-1:0]   age_inc;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE) && !r_ov;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid    = r_ov;
    assign o_status       = r_res_st;
    assign o_entry_index  = OUT_IDX_W'(r_res_idx);
    assign o_mac_out      = r_res_mac;
    assign o_send_request = r_res_req;
    assign o_send_packet  = r_res_snd;

    // One read port into the table, steered by the sequencer
    always_comb begin
        case (r_state)
            S_LAST:  rd_idx = r_last;
            S_APPLY: rd_idx = r_idx;
            default: rd_idx = r_cnt;
        endcase
    end

    assign rd_st   = r_status[rd_idx];
    assign age_inc = r_age[rd_idx] + AGE_W'(1);

    arc_cmp u_cmp (
        .i_ent_hi  (r_ent_hi[rd_idx]),
        .i_ent_lo  (r_ent_lo[rd_idx]),
        .i_ent_v   (r_ent_v[rd_idx]),
        .i_key_hi  (r_hi),
        .i_key_lo  (r_lo),
        .i_key_v   (r_v),
        .i_ent_age (r_age[rd_idx]),
        .i_ref_age ((rd_st == ENT_PENDING) ? r_op_age : r_os_age),
        .o_res     (cmp)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_action)
                        ACT_QUERY:  n_state = S_LAST;
                        ACT_UPDATE: n_state = S_LAST;
                        ACT_TICK:   n_state = S_TICK;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_LAST: begin
                if (rd_st == ENT_STABLE && cmp.match) n_state = S_APPLY;
                else                                  n_state = S_SWEEP;
            end
            S_SWEEP: begin
                if (rd_st != ENT_EMPTY && cmp.match) n_state = S_APPLY;
                else if (r_cnt == LAST_IDX)          n_state = S_PICK;
            end
            S_PICK: begin
                if (r_fe_vld)                              n_state = S_APPLY;
                else if ((r_act == ACT_QUERY || r_rcy)
                         && (r_os_vld || r_op_vld))        n_state = S_APPLY;
                else                                       n_state = S_IDLE;
            end
            S_APPLY: n_state = S_IDLE;
            S_TICK: begin
                if (r_cnt == LAST_IDX) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Control state, table status and age
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                r_status[k] <= ENT_EMPTY;
                r_age[k]    <= '0;
            end
            r_last        <= '0;
            r_stable_lim  <= STABLE_LIMIT_RST;
            r_pending_lim <= PENDING_LIMIT_RST;
            r_ov          <= 1'b0;
            r_cnt         <= '0;
            r_fe_vld      <= 1'b0;
            r_os_vld      <= 1'b0;
            r_op_vld      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STABLE_LIMIT:  r_stable_lim  <= i_cfg_data;
                    CFG_PENDING_LIMIT: r_pending_lim <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ov && i_out_ready) r_ov <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    r_cnt    <= '0;
                    r_fe_vld <= 1'b0;
                    r_os_vld <= 1'b0;
                    r_op_vld <= 1'b0;
                    r_os_age <= '0;
                    r_op_age <= '0;
                    if (in_acc && i_action != ACT_QUERY && i_action != ACT_UPDATE
                        && i_action != ACT_TICK) begin
                        // unused code: empty result at once
                        r_ov      <= 1'b1;
                        r_res_st  <= RES_OK;
                        r_res_idx <= '0;
                        r_res_mac <= '0;
                        r_res_req <= 1'b0;
                        r_res_snd <= 1'b0;
                    end
                end
                S_LAST: begin
                    r_idx <= r_last;
                end
                S_SWEEP: begin
                    r_cnt <= r_cnt + IDX_W'(1);
                    if (!r_fe_vld && rd_st == ENT_EMPTY) begin
                        r_fe_vld <= 1'b1;
                        r_fe     <= r_cnt;
                    end else if (rd_st != ENT_EMPTY) begin
                        if (cmp.match) begin
                            r_idx  <= r_cnt;
                            r_last <= r_cnt;
                        end else if (cmp.age_ge) begin
                            // ties go to the higher index
                            if (rd_st == ENT_PENDING) begin
                                r_op_vld <= 1'b1;
                                r_op     <= r_cnt;
                                r_op_age <= r_age[r_cnt];
                            end else begin
                                r_os_vld <= 1'b1;
                                r_os     <= r_cnt;
                                r_os_age <= r_age[r_cnt];
                            end
                        end
                    end
                end
                S_PICK: begin
                    if (n_state == S_APPLY) begin
                        // free or recycled entry: emptied, address taken, age cleared
                        logic [IDX_W-1:0] pick;
                        pick = r_fe_vld ? r_fe : (r_os_vld ? r_os : r_op);
                        r_status[pick] <= ENT_EMPTY;
                        r_age[pick]    <= '0;
                        r_last         <= pick;
                        r_idx          <= pick;
                    end else begin
                        r_ov      <= 1'b1;
                        r_res_st  <= RES_NO_ENTRY;
                        r_res_idx <= '0;
                        r_res_mac <= '0;
                        r_res_req <= 1'b0;
                        r_res_snd <= 1'b0;
                    end
                end
                S_APPLY: begin
                    r_ov      <= 1'b1;
                    r_res_idx <= r_idx;
                    if (r_act == ACT_QUERY) begin
                        if (rd_st == ENT_EMPTY) r_status[r_idx] <= ENT_PENDING;
                        r_res_req <= (rd_st != ENT_STABLE) || !r_pkt;
                        r_res_snd <= r_pkt && (rd_st == ENT_STABLE);
                        r_res_mac <= (r_pkt && rd_st == ENT_STABLE) ? r_ent_mac[r_idx] : '0;
                        r_res_st  <= (r_pkt && rd_st != ENT_STABLE) ? RES_UNRESOLVED : RES_OK;
                    end else begin
                        r_status[r_idx] <= ENT_STABLE;
                        r_age[r_idx]    <= '0;
                        r_res_req       <= 1'b0;
                        r_res_snd       <= 1'b0;
                        r_res_mac       <= '0;
                        r_res_st        <= RES_OK;
                    end
                end
                S_TICK: begin
                    r_cnt        <= r_cnt + IDX_W'(1);
                    r_age[r_cnt] <= age_inc;
                    if ((rd_st == ENT_STABLE && age_inc >= r_stable_lim)
                        || (rd_st == ENT_PENDING && age_inc >= r_pending_lim))
                        r_status[r_cnt] <= ENT_EMPTY;
                    if (r_cnt == LAST_IDX) begin
                        r_ov      <= 1'b1;
                        r_res_st  <= RES_OK;
                        r_res_idx <= '0;
                        r_res_mac <= '0;
                        r_res_req <= 1'b0;
                        r_res_snd <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload: captured item, entry address and MAC
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act <= i_action;
            r_hi  <= i_addr_high;
            r_lo  <= i_addr_low;
            r_v   <= i_is_ipv6;
            r_mac <= i_mac_in;
            r_pkt <= i_has_packet;
            r_rcy <= i_allow_recycle;
        end
        if (r_state == S_PICK && n_state == S_APPLY) begin
            r_ent_hi[r_fe_vld ? r_fe : (r_os_vld ? r_os : r_op)] <= r_hi;
            r_ent_lo[r_fe_vld ? r_fe : (r_os_vld ? r_os : r_op)] <= r_lo;
            r_ent_v[r_fe_vld ? r_fe : (r_os_vld ? r_os : r_op)]  <= r_v;
        end
        if (r_state == S_APPLY && r_act == ACT_UPDATE)
            r_ent_mac[r_idx] <= r_mac;
    end

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input accepted while an item is in flight");

    a_no_entry_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == RES_NO_ENTRY) |-> (!o_send_packet && !o_send_request))
        else $error("send flag with no entry available");

    a_send_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_send_packet) |-> (o_status == RES_OK))
        else $error("packet sent with non-ok status");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) != S_IDLE || $past(in_acc)))
        else $error("result without an item");

endmodule
